FILE: src/qch_pkg.sv
// Package for the quantized color histogram: payload types and codes.
package qch_pkg;

   localparam int PIXEL_BITS  = 8;
   localparam int WIDE_W      = 3 * PIXEL_BITS;
   localparam int BIN_W       = 12;
   localparam int COUNT_OUT_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int BPC_W       = 3;

   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_READ_CLEAR = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE       = 2'd1;

   localparam logic [BPC_W-1:0] BPC_RESET  = 3'd2;
   localparam logic             MODE_RESET = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [PIXEL_BITS-1:0] red;
      logic [PIXEL_BITS-1:0] green;
      logic [PIXEL_BITS-1:0] blue;
      logic [PIXEL_BITS-1:0] grey;
      logic [BIN_W-1:0]      bin_index;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]       bin;
      logic [COUNT_OUT_W-1:0] count;
   } rsp_type;

endpackage

FILE: src/qch_ram.sv
// Generic single-clock RAM, one write port, one read port with registered read data.
module qch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/quantized_color_histogram.sv
// Quantized color histogram: bins pixels by their top bits, read-and-clear readout.
//
// Input channel (req_*): one item per transfer. cmd accumulate bins the pixel
// (RGB or grey, per color_mode) using the top bits_per_channel bits of each
// component; cmd read-and-clear returns the count of bin_index and zeroes it.
// Result channel (rsp_*): exactly one result per item, in order: the bin touched
// and its new count (accumulate) or its old count (read).
// Config port (csr_*): always ready; index 0 bits_per_channel, 1 color_mode.
// Write only while no item is in flight.
// Result path: the item passes the read stage, then the output register, which
// drives rsp_valid.
// Throughput: one item per cycle while req_stall is low. The histogram RAM is
// read in the transfer cycle and written back when the item leaves the read
// stage; a back-to-back hit on the same bin is forwarded from the write-back value.
// Reset: synchronous. Afterwards a clearing pass zeroes all 2**(3*MAX_BITS) RAM
// entries (4096 by default), one entry a cycle; req_stall is high meanwhile.
// Stall: while rsp_stall holds a result, the item behind it waits in the
// read stage and req_stall rises until the result is taken.
module quantized_color_histogram #(
   parameter int MAX_BITS    = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qch_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qch_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qch_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [qch_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qch_pkg::*;

   localparam int IDX_W = 3 * MAX_BITS;
   localparam int DEPTH = 1 << IDX_W;
   localparam logic [3:0] MAX_N = 4'(MAX_BITS);
   localparam logic [3:0] PIX_N = 4'(PIXEL_BITS);

   // configuration
   logic [BPC_W-1:0] bpc_ff, bpc_in;
   logic             mode_ff, mode_in;

   // clearing pass
   logic             clr_ff, clr_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   // read stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_cmd_ff, s1_cmd_in;
   logic [IDX_W-1:0]       s1_idx_ff, s1_idx_in;
   logic                   fwd_ff, fwd_in;
   logic [COUNT_WIDTH-1:0] fwd_data_ff, fwd_data_in;

   // output register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic                   accept;
   logic                   s1_adv;
   logic [3:0]             n_bits;
   logic [3:0]             rsh;
   logic [4:0]             lsh2;
   logic [WIDE_W-1:0]      r_top, g_top, b_top, y_top, pix_wide, rd_wide;
   logic [IDX_W-1:0]       acc_idx, req_idx;
   logic [COUNT_WIDTH-1:0] ram_rdata, cur_cnt, inc_cnt, wr_cnt;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [COUNT_WIDTH-1:0] ram_wdata;
   logic [WIDE_W-1:0]      bin_wide;
   logic [63:0]            cnt_wide;

   assign csr_ready = 1'b1;

   // effective bits per component, clamped to 1..MAX_BITS
   always_comb begin
      n_bits = {1'b0, bpc_ff};
      if (n_bits == 4'd0) begin
         n_bits = 4'd1;
      end
      if (n_bits > MAX_N) begin
         n_bits = MAX_N;
      end
      rsh  = PIX_N - n_bits;
      lsh2 = {n_bits, 1'b0};
   end

   always_comb begin
      r_top    = {{(WIDE_W-PIXEL_BITS){1'b0}}, req_data.red   >> rsh};
      g_top    = {{(WIDE_W-PIXEL_BITS){1'b0}}, req_data.green >> rsh};
      b_top    = {{(WIDE_W-PIXEL_BITS){1'b0}}, req_data.blue  >> rsh};
      y_top    = {{(WIDE_W-PIXEL_BITS){1'b0}}, req_data.grey  >> rsh};
      pix_wide = mode_ff ? ((r_top << lsh2) | (g_top << n_bits) | b_top) : y_top;
      rd_wide  = {{(WIDE_W-BIN_W){1'b0}}, req_data.bin_index};
      acc_idx  = pix_wide[IDX_W-1:0];
      req_idx  = (req_data.cmd == CMD_READ_CLEAR) ? rd_wide[IDX_W-1:0] : acc_idx;
   end

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = clr_ff || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   // modify: saturating increment or read-and-clear
   always_comb begin
      cur_cnt = fwd_ff ? fwd_data_ff : ram_rdata;
      inc_cnt = (cur_cnt == {COUNT_WIDTH{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
      wr_cnt  = (s1_cmd_ff == CMD_READ_CLEAR) ? '0 : inc_cnt;
   end

   always_comb begin
      ram_we    = clr_ff || s1_adv;
      ram_waddr = clr_ff ? clr_addr_ff : s1_idx_ff;
      ram_wdata = clr_ff ? '0 : wr_cnt;
   end

   always_comb begin
      bpc_in  = bpc_ff;
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BITS_PER_CHANNEL: bpc_in  = csr_wdata[BPC_W-1:0];
            CSR_COLOR_MODE:       mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {IDX_W{1'b1}}) begin
            clr_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_idx_in   = s1_idx_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_data.cmd;
         s1_idx_in   = req_idx;
         // same bin written this cycle: RAM read returns the stale count
         fwd_in      = s1_adv && (s1_idx_ff == req_idx);
         fwd_data_in = wr_cnt;
      end

      bin_wide = {{(WIDE_W-IDX_W){1'b0}}, s1_idx_ff};
      cnt_wide = {{(64-COUNT_WIDTH){1'b0}},
                  (s1_cmd_ff == CMD_READ_CLEAR) ? cur_cnt : inc_cnt};

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         out_valid_in      = 1'b1;
         out_data_in.bin   = bin_wide[BIN_W-1:0];
         out_data_in.count = cnt_wide[COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff       <= BPC_RESET;
         mode_ff      <= MODE_RESET;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bpc_ff       <= bpc_in;
         mode_ff      <= mode_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= s1_cmd_in;
      s1_idx_ff   <= s1_idx_in;
      fwd_data_ff <= fwd_data_in;
      out_data_ff <= out_data_in;
   end

   qch_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_hist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (req_idx),
      .rdata (ram_rdata)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: dv/quantized_color_histogram_test.sv
// Self-checking testbench for the quantized color histogram block.
`timescale 1ns / 100ps

module quantized_color_histogram_test;
   import qch_pkg::*;

   localparam int MAX_BITS = 4;
   localparam int CNT_W = 32;
   localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;
   localparam int HIST_BINS = 1 << BIN_W;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_LIMIT = 6 * (HIST_BINS + HOLD_CYCLES);
   localparam int END_CYCLES = 8;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 143;
   localparam int REPEAT_HITS = 259;
   localparam int ERROR_PRINT_CAP = 50;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Histogram model and its configuration
   logic [CNT_W-1:0] model_bins [HIST_BINS];
   logic [BPC_W-1:0] model_bpc = BPC_RESET;
   logic model_rgb = MODE_RESET;
   rsp_type expected_bin_counts[$];

   int error_count = 0;
   int items_sent = 0;
   int reads_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int hold_requests = 0;
   bit steady_flow = 1'b0;
   int idle_cycles = 0;

   quantized_color_histogram #(
      .MAX_BITS(MAX_BITS),
      .COUNT_WIDTH(CNT_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < ERROR_PRINT_CAP)
         $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int effective_bits();
      int n;
      n = model_bpc;
      if (n < 1) n = 1;
      if (n > MAX_BITS) n = MAX_BITS;
      return n;
   endfunction

   task automatic predict_bin_count(input req_type item);
      rsp_type r;
      int n;
      logic [BIN_W-1:0] idx;
      logic [BIN_W-1:0] r_top, g_top, b_top, y_top;
      logic [CNT_W-1:0] cnt;
      n = effective_bits();
      if (item.cmd == CMD_READ_CLEAR) begin
         idx = item.bin_index;
         cnt = model_bins[idx];
         model_bins[idx] = '0;
      end else begin
         r_top = item.red >> (PIXEL_BITS - n);
         g_top = item.green >> (PIXEL_BITS - n);
         b_top = item.blue >> (PIXEL_BITS - n);
         y_top = item.grey >> (PIXEL_BITS - n);
         if (model_rgb) idx = (r_top << (2 * n)) | (g_top << n) | b_top;
         else idx = y_top;
         cnt = model_bins[idx];
         if (cnt != COUNT_LIMIT) cnt++;
         model_bins[idx] = cnt;
      end
      r.bin = idx;
      r.count = cnt;
      expected_bin_counts.push_back(r);
   endtask

   function automatic req_type pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] y);
      req_type it;
      it.cmd = CMD_ACCUMULATE;
      it.red = r;
      it.green = g;
      it.blue = b;
      it.grey = y;
      it.bin_index = BIN_W'($urandom);
      return it;
   endfunction

   function automatic req_type read_bin(input logic [BIN_W-1:0] idx);
      req_type it;
      it = pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      it.cmd = CMD_READ_CLEAR;
      it.bin_index = idx;
      return it;
   endfunction

   // Mostly accumulates; reads mostly land in bins the current setting can fill.
   function automatic req_type random_item();
      int span;
      span = effective_bits() * (model_rgb ? 3 : 1);
      if ($urandom_range(0, 99) < 25) begin
         if ($urandom_range(0, 9) < 8) return read_bin(BIN_W'($urandom_range(0, (1 << span) - 1)));
         return read_bin(BIN_W'($urandom));
      end
      return pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   task automatic push_request(input req_type item);
      csr_valid <= 1'b0;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_bin_count(item);
      items_sent++;
      if (item.cmd == CMD_READ_CLEAR) reads_sent++;
      if (!steady_flow && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bin_counts.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays up after the transfer until push_request drops it for the next item.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_BITS_PER_CHANNEL: model_bpc = data[BPC_W-1:0];
         CSR_COLOR_MODE:       model_rgb = data[0];
         default: ;
      endcase
   endtask

   task automatic test_default_config();
      steady_flow = 1'b1;
      push_request(pixel(8'h00, 8'h00, 8'h00, 8'hFF));
      push_request(pixel(8'h00, 8'h00, 8'h00, 8'hFF));  // same bin back to back
      push_request(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
      push_request(pixel(8'hFF, 8'h00, 8'h80, 8'hFF));
      push_request(read_bin(12'd0));
      push_request(read_bin(12'd0));  // cleared by the read before
      push_request(read_bin(12'd63));
      push_request(read_bin(12'hFFF));
      steady_flow = 1'b0;
   endtask

   task automatic test_register_extremes();
      write_register(CSR_BITS_PER_CHANNEL, 8'd0);  // zero acts as one bit
      write_register(CSR_COLOR_MODE, 8'd0);
      push_request(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
      push_request(pixel(8'h00, 8'h00, 8'h00, 8'hFF));
      push_request(read_bin(12'd1));
      write_register(CSR_BITS_PER_CHANNEL, 8'hFF);  // seven clamps to four
      push_request(pixel(8'h00, 8'h00, 8'h00, 8'hFF));
      push_request(pixel(8'h00, 8'h00, 8'h00, 8'h80));
      write_register(CSR_COLOR_MODE, 8'hFF);
      push_request(pixel(8'hFF, 8'h00, 8'hFF, 8'h00));
      push_request(pixel(8'h80, 8'h40, 8'h20, 8'hFF));
      write_register(CSR_SPARE_2, 8'h00);
      write_register(CSR_SPARE_3, 8'hFF);
      push_request(pixel(8'h80, 8'h40, 8'h20, 8'h00));
      push_request(read_bin(12'h842));
      write_register(CSR_BITS_PER_CHANNEL, 8'hF9);  // only the low three bits count
      push_request(pixel(8'hFF, 8'h7F, 8'hFF, 8'h00));
      push_request(read_bin(12'd5));
   endtask

   // One bin hit back to back for a long run, then read twice.
   task automatic test_repeated_hits();
      write_register(CSR_BITS_PER_CHANNEL, 8'd1);
      write_register(CSR_COLOR_MODE, 8'd0);
      steady_flow = 1'b1;
      repeat (REPEAT_HITS)
         push_request(pixel(8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom_range(128, 255))));
      push_request(read_bin(12'd1));
      push_request(read_bin(12'd1));
      steady_flow = 1'b0;
   endtask

   // Results are held off while items keep coming, then the sender waits for all.
   task automatic test_result_hold_off();
      steady_flow = 1'b1;
      hold_requests++;
      repeat (40) push_request(random_item());
      wait_drained();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_phases();
      logic [BPC_W-1:0] bpc_pick [8] = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6};
      for (int p = 0; p < PHASES; p++) begin
         write_register(CSR_BITS_PER_CHANNEL, {5'($urandom), bpc_pick[p % 8]});
         write_register(CSR_COLOR_MODE, {7'($urandom), 1'(p % 3 != 0)});
         if (p == 6) write_register(CSR_SPARE_2, 8'($urandom));
         steady_flow = (p == 4);
         repeat (PHASE_ITEMS) push_request(random_item());
      end
      steady_flow = 1'b0;
   endtask

   initial begin : result_receiver
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 32);
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_bin_counts.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding", rsp_data.count, '0);
         end else begin
            want = expected_bin_counts.pop_front();
            if (rsp_data.bin !== want.bin) report_mismatch("bin", rsp_data.bin, want.bin);
            if (rsp_data.count !== want.count)
               report_mismatch("count", rsp_data.count, want.count);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_tests
      foreach (model_bins[i]) model_bins[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_register_extremes();
      test_repeated_hits();
      test_result_hold_off();
      test_random_phases();
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_bin_counts.size() != 0)
         report_mismatch("results never delivered", expected_bin_counts.size(), '0);
      $display("Covered %0d items (%0d read-and-clear), %0d results, %0d register writes",
               items_sent, reads_sent, results_checked, csr_writes);
      $display("Bit widths 0 to 7 in grey and RGB modes, long same-bin runs, one hold-off");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
